// ===== sv/rational_arith_normalize_top_defines.svh =====
// assertion macros shared by the rtl files
`ifndef RATIONAL_ARITH_NORMALIZE_TOP_DEFINES_SVH
`define RATIONAL_ARITH_NORMALIZE_TOP_DEFINES_SVH

// same-cycle implication
`define RN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ratnorm_pkg.sv =====
package ratnorm_pkg;

   localparam int WORD_BITS = 64;
   localparam int HALF_BITS = WORD_BITS / 2;
   localparam int CNT_BITS  = $clog2(WORD_BITS);

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      cmd_type  cmd;
      word_type a_num;
      word_type a_den;
      word_type b_num;
      word_type b_den;
   } req_type;

   typedef struct packed {
      word_type res_num;
      word_type res_den;
   } rsp_type;

   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      word_type quot;
      word_type rem;
   } div_rsp_type;

   // two's complement magnitude, the most negative value maps to itself
   function automatic word_type wabs(input word_type v);
      return v[WORD_BITS-1] ? word_type'(-v) : v;
   endfunction

endpackage

// ===== sv/rational_arith_normalize_top.sv =====
// rational add / subtract / multiply / divide with gcd reduction
//
// start with req_data presents a transaction; it is taken at a rising edge where
// start is high and busy is low. busy stays high until the result is produced.
// the result appears on rsp_data for exactly one cycle with rsp_valid high; the
// receiver cannot stall it. busy drops in the cycle rsp_valid is shown, so a new
// transaction may be started then.
//
// each of the three 64-bit products is accumulated from 32x32 partial products; they
// are combined, then k euclid remainder steps and two exact quotients follow on the
// 64-iteration shared bit-serial divider; k is data dependent (0 up to about 92
// for 64-bit words). a new transaction is not taken until the result of the
// previous one has been shown.
//
// reset (synchronous, active high) returns the sequencer to idle and drops any
// transaction in progress; no result is emitted for it.
`include "rational_arith_normalize_top_defines.svh"

module rational_arith_normalize_top
   import ratnorm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MUL  = 7'b0000010,
      S_COMB = 7'b0000100,
      S_GCD  = 7'b0001000,
      S_REM  = 7'b0010000,
      S_QNUM = 7'b0100000,
      S_QDEN = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [1:0] pidx_ff, pidx_in;
   logic [1:0] pstep_ff, pstep_in;
   word_type  acc_ff, acc_in;
   word_type  prod_ff [3];
   logic      prod_we;
   word_type  num_ff, num_in;
   word_type  den_ff, den_in;
   word_type  x_ff, x_in;
   word_type  y_ff, y_in;
   word_type  g_ff, g_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   word_type  mul_x, mul_y;
   logic [HALF_BITS-1:0] mx, my;
   logic [WORD_BITS-1:0] mprod;
   word_type  comb_num;
   word_type  gsel;

   div_req_type div_req;
   div_rsp_type div_rsp;

   ratnorm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // operand pair for each of the three products
   always_comb begin
      case (pidx_ff)
         2'd0: begin
            mul_x = req_ff.a_num;
            mul_y = (req_ff.cmd == CMD_MUL) ? req_ff.b_num : req_ff.b_den;
         end
         2'd1: begin
            mul_x = req_ff.b_num;
            mul_y = req_ff.a_den;
         end
         default: begin
            mul_x = req_ff.a_den;
            mul_y = (req_ff.cmd == CMD_DIV) ? req_ff.b_num : req_ff.b_den;
         end
      endcase
      case (pstep_ff)
         2'd0: begin
            mx = mul_x[HALF_BITS-1:0];
            my = mul_y[HALF_BITS-1:0];
         end
         2'd1: begin
            mx = mul_x[HALF_BITS-1:0];
            my = mul_y[WORD_BITS-1:HALF_BITS];
         end
         default: begin
            mx = mul_x[WORD_BITS-1:HALF_BITS];
            my = mul_y[HALF_BITS-1:0];
         end
      endcase
   end

   assign mprod = mx * my;

   always_comb begin
      case (req_ff.cmd)
         CMD_ADD: comb_num = prod_ff[0] + prod_ff[1];
         CMD_SUB: comb_num = prod_ff[0] - prod_ff[1];
         default: comb_num = prod_ff[0];
      endcase
   end

   assign gsel = (x_ff == '0) ? word_type'(1) : x_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      pidx_in      = pidx_ff;
      pstep_in     = pstep_ff;
      acc_in       = acc_ff;
      prod_we      = 1'b0;
      num_in       = num_ff;
      den_in       = den_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      g_in         = g_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      div_req      = '{start: 1'b0, dividend: x_ff, divisor: y_ff};

      if (pstep_ff == 2'd0) begin
         acc_in = word_type'(mprod);
      end else begin
         acc_in = {acc_ff[WORD_BITS-1:HALF_BITS] + mprod[HALF_BITS-1:0],
                   acc_ff[HALF_BITS-1:0]};
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               pidx_in  = 2'd0;
               pstep_in = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (pstep_ff == 2'd2) begin
               prod_we  = 1'b1;
               pstep_in = 2'd0;
               pidx_in  = pidx_ff + 2'd1;
               if (pidx_ff == 2'd2) begin
                  state_in = S_COMB;
               end
            end else begin
               pstep_in = pstep_ff + 2'd1;
            end
         end
         S_COMB: begin
            num_in   = comb_num;
            den_in   = prod_ff[2];
            x_in     = wabs(comb_num);
            y_in     = wabs(prod_ff[2]);
            state_in = S_GCD;
         end
         S_GCD: begin
            if (y_ff == '0) begin
               g_in     = gsel;
               div_req  = '{start: 1'b1, dividend: num_ff, divisor: gsel};
               state_in = S_QNUM;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_REM;
            end
         end
         S_REM: begin
            if (div_rsp.done) begin
               x_in     = y_ff;
               y_in     = div_rsp.rem;
               state_in = S_GCD;
            end
         end
         S_QNUM: begin
            if (div_rsp.done) begin
               num_in   = div_rsp.quot;
               div_req  = '{start: 1'b1, dividend: den_ff, divisor: g_ff};
               state_in = S_QDEN;
            end
         end
         S_QDEN: begin
            if (div_rsp.done) begin
               // move the sign to the numerator
               if (div_rsp.quot[WORD_BITS-1]) begin
                  rsp_in.res_num = word_type'(-num_ff);
                  rsp_in.res_den = word_type'(-div_rsp.quot);
               end else begin
                  rsp_in.res_num = num_ff;
                  rsp_in.res_den = div_rsp.quot;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      pidx_ff  <= pidx_in;
      pstep_ff <= pstep_in;
      acc_ff   <= acc_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      g_ff     <= g_in;
      rsp_ff   <= rsp_in;
      if (prod_we) begin
         prod_ff[pidx_ff] <= acc_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `RN_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
   `RN_ASSERT_NEXT(a_rsp_source, state_ff == S_QDEN && div_rsp.done, rsp_valid, "missing result")
   `RN_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "result shown while busy")
   `RN_ASSERT_NOW(a_den_sign, rsp_valid,
      !rsp_data.res_den[WORD_BITS-1] || rsp_data.res_den == {1'b1, {(WORD_BITS-1){1'b0}}},
      "negative reduced denominator")

endmodule

// ===== sv/ratnorm_div.sv =====
`include "rational_arith_normalize_top_defines.svh"

module ratnorm_div
   import ratnorm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [WORD_BITS-1:0]  quo_ff, quo_in;
   logic [WORD_BITS-1:0]  rem_ff, rem_in;
   logic [WORD_BITS-1:0]  dvs_ff, dvs_in;
   logic                  qneg_ff, qneg_in;
   logic                  rneg_ff, rneg_in;

   logic [WORD_BITS:0]    shifted;
   logic [WORD_BITS:0]    diff;
   logic                  fits;

   // one restoring step on magnitudes
   assign shifted = {rem_ff, quo_ff[WORD_BITS-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = !diff[WORD_BITS];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = wabs(div_req.dividend);
         rem_in  = '0;
         dvs_in  = wabs(div_req.divisor);
         qneg_in = div_req.dividend[WORD_BITS-1] ^ div_req.divisor[WORD_BITS-1];
         rneg_in = div_req.dividend[WORD_BITS-1];
      end else if (busy_ff) begin
         quo_in = {quo_ff[WORD_BITS-2:0], fits};
         rem_in = fits ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   // truncating signed results
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = qneg_ff ? word_type'(-quo_ff) : word_type'(quo_ff);
   assign div_rsp.rem  = rneg_ff ? word_type'(-rem_ff) : word_type'(rem_ff);

   `RN_ASSERT_NOW(a_div_no_restart, div_req.start, !busy_ff, "divider restarted while busy")
   `RN_ASSERT_NEXT(a_div_done_pulse, done_ff, !done_ff, "divider done held")
   `RN_ASSERT_NOW(a_div_rem_bound, busy_ff, rem_ff < dvs_ff, "partial remainder not below divisor")

endmodule
